FILE: rtl/detection_box_grouping_top_defines.svh
// assertion macros for the box grouping block
`ifndef DETECTION_BOX_GROUPING_TOP_DEFINES_SVH
`define DETECTION_BOX_GROUPING_TOP_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define GBX_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gbx check failed");

// next-cycle implication, checked while out of reset
`define GBX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gbx check failed");

`endif

FILE: rtl/gbx_pkg.sv
// ----------------------------------------------------------------------------
// gbx_pkg
// shared constants of the detection box grouping block
// ----------------------------------------------------------------------------
package gbx_pkg;

    // default box capacity and coordinate width
    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 12;

    // signed Q16.16 confidence
    localparam int SCORE_W = 32;

endpackage

FILE: rtl/detection_box_grouping_top.sv
// Boxes load one per cycle while idle; after the final box the sequencer runs pair checks,
// cluster merges, labeling and sums, a division in the shared divider for each averaged
// field of a kept cluster, and the nesting pass.
// Throughput: one set at a time; busy stays high from the final box to the last result.
// Results come one per cycle strobe and cannot be stalled by the receiver.
// Reset (synchronous, active low) clears control state and sets min_members to 1.
// ----------------------------------------------------------------------------
// detection_box_grouping_top
// clusters detection boxes with a small sequencer and a shared divider
// ----------------------------------------------------------------------------
module detection_box_grouping_top
    import gbx_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [COORD_BITS-1:0]             i_box_left,
    input  logic [COORD_BITS-1:0]             i_box_top,
    input  logic [COORD_BITS-1:0]             i_box_width,
    input  logic [COORD_BITS-1:0]             i_box_height,
    input  logic signed [SCORE_W-1:0]         i_box_score,
    input  logic                              i_final_box,
    input  logic                              i_cfg_we,
    input  logic [$clog2(MAX_BOXES+1)-1:0]    i_cfg_wdata,
    output logic                              o_valid,
    output logic                              o_has_box,
    output logic [COORD_BITS-1:0]             o_out_left,
    output logic [COORD_BITS-1:0]             o_out_top,
    output logic [COORD_BITS-1:0]             o_out_width,
    output logic [COORD_BITS-1:0]             o_out_height,
    output logic [$clog2(MAX_BOXES+1)-1:0]    o_member_total,
    output logic signed [SCORE_W-1:0]         o_out_score,
    output logic                              o_final_result
);

    localparam int CB    = COORD_BITS;
    localparam int IDX_W = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int SUM_W = CB + CNT_W;
    localparam int DVD_W = SUM_W + 1;
    localparam int DVS_W = CNT_W + 1;
    localparam int E_W   = CB + 5;
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_BOXES);
    localparam logic [CNT_W-1:0] THREE = CNT_W'(3);

    typedef struct packed {
        logic [CB-1:0]      x;
        logic [CB-1:0]      y;
        logic [CB-1:0]      w;
        logic [CB-1:0]      h;
        logic [SCORE_W-1:0] s;
    } t_box;

    typedef struct packed {
        logic [SUM_W-1:0]   sx;
        logic [SUM_W-1:0]   sy;
        logic [SUM_W-1:0]   sw;
        logic [SUM_W-1:0]   sh;
        logic [CNT_W-1:0]   n;
        logic [SCORE_W-1:0] best;
    } t_acc;

    typedef struct packed {
        logic [CB-1:0]      x;
        logic [CB-1:0]      y;
        logic [CB-1:0]      w;
        logic [CB-1:0]      h;
        logic [CNT_W-1:0]   n;
        logic [SCORE_W-1:0] s;
    } t_av;

    typedef struct packed {
        logic             v;
        logic [IDX_W-1:0] c;
    } t_cof;

    typedef enum logic [22:0] {
        ST_LOAD     = 23'h000001,
        ST_PI_RD    = 23'h000002,
        ST_PI_GET   = 23'h000004,
        ST_PJ_RD    = 23'h000008,
        ST_PJ_CHK   = 23'h000010,
        ST_SW_RD    = 23'h000020,
        ST_SW_CHK   = 23'h000040,
        ST_NUM_RD   = 23'h000080,
        ST_NUM_GET  = 23'h000100,
        ST_NUM_MAP  = 23'h000200,
        ST_CLR      = 23'h000400,
        ST_ACC_RD   = 23'h000800,
        ST_ACC_GET  = 23'h001000,
        ST_ACC_UPD  = 23'h002000,
        ST_AVG_RD   = 23'h004000,
        ST_AVG_GET  = 23'h008000,
        ST_AVG_DIV  = 23'h010000,
        ST_AVG_WAIT = 23'h020000,
        ST_NST_RDI  = 23'h040000,
        ST_NST_GETI = 23'h080000,
        ST_NST_RDJ  = 23'h100000,
        ST_NST_CHK  = 23'h200000,
        ST_DONE     = 23'h400000
    } t_state;

    // closeness of box b to box a, margins scaled by 4 and 2
    function automatic logic near_box(input t_box a, input t_box b);
        logic [E_W-1:0] ax, ay, bx, by, wa, wb;
        ax = E_W'(a.x) << 2;
        ay = E_W'(a.y) << 2;
        bx = E_W'(b.x) << 2;
        by = E_W'(b.y) << 2;
        wa = E_W'(a.w);
        wb = E_W'(b.w);
        near_box = (bx <= ax + wa + E_W'(2)) && (bx + wa + E_W'(2) >= ax) &&
                   (by <= ay + wa + E_W'(2)) && (by + wa + E_W'(2) >= ay) &&
                   ((wb << 1) <= wa + (wa << 1) + E_W'(1)) &&
                   ((wa << 1) <= wb + (wb << 1) + E_W'(1));
    endfunction

    // survivor a lies inside survivor b, where b has more members than both a and three, or a has under three
    function automatic logic nested_in(input t_av a, input t_av b);
        logic [E_W-1:0]   d, axl, ayl, bxl, byl, axr, ayb, bxr, byb;
        logic [CNT_W-1:0] big;
        logic             enclosed;
        d   = E_W'(b.w) + E_W'(2);
        axl = E_W'(a.x) << 2;
        ayl = E_W'(a.y) << 2;
        bxl = E_W'(b.x) << 2;
        byl = E_W'(b.y) << 2;
        axr = (E_W'(a.x) + E_W'(a.w)) << 2;
        ayb = (E_W'(a.y) + E_W'(a.h)) << 2;
        bxr = (E_W'(b.x) + E_W'(b.w)) << 2;
        byb = (E_W'(b.y) + E_W'(b.h)) << 2;
        enclosed = (axl + d >= bxl) && (ayl + d >= byl) &&
                   (axr <= bxr + d) && (ayb <= byb + d);
        big = (a.n > THREE) ? a.n : THREE;
        nested_in = enclosed && ((b.n > big) || (a.n < THREE));
    endfunction

    function automatic logic is_empty(input t_box b);
        is_empty = (b.w == '0) || (b.h == '0);
    endfunction

    t_state           r_state;
    logic [CNT_W-1:0] r_min;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_i, r_j, r_k;
    logic [CNT_W-1:0] r_cc;
    logic [CNT_W-1:0] r_kept;
    logic [IDX_W-1:0] r_li, r_lo, r_hi;
    logic [IDX_W-1:0] r_c;
    logic [1:0]       r_q;
    logic             r_pend;
    t_box             r_bi;
    t_box             r_bj;
    t_acc             r_acc;
    t_av              r_ai;
    t_av              r_pbox;
    logic [CB-1:0]    r_avx, r_avy, r_avw;

    logic                    r_o_valid, r_o_has, r_o_final;
    t_av                     r_o_box;

    // memories
    t_box             m_box [MAX_BOXES];
    logic [IDX_W-1:0] m_lab [MAX_BOXES];
    logic [IDX_W-1:0] m_num [MAX_BOXES];
    t_cof             m_cof [MAX_BOXES];
    t_acc             m_acc [MAX_BOXES];
    t_av              m_av  [MAX_BOXES];

    t_box             box_rd;
    logic [IDX_W-1:0] lab_rd, num_rd;
    t_cof             cof_rd;
    t_acc             acc_rd;
    t_av              av_rd;

    logic             box_we, lab_we, num_we, cof_we, acc_we, av_we;
    logic [IDX_W-1:0] box_ra, lab_ra, acc_ra, av_ra;
    logic [IDX_W-1:0] lab_wa, acc_wa;
    logic [IDX_W-1:0] lab_wd;
    t_box             box_wd;
    t_cof             cof_wd;
    t_acc             acc_wd;
    t_av              av_wd;

    logic             load_acc;
    logic             last_i, last_j, last_k;
    logic             pair_hit, root_i;
    logic [SUM_W-1:0] sel_sum;
    logic             div_start, div_done;
    logic [DVD_W-1:0] div_quot;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;

    // loop bounds and pair decision
    always_comb begin
        load_acc = (r_state == ST_LOAD) && start;
        last_i   = CNT_W'(r_i + 1'b1) == r_cnt;
        last_j   = CNT_W'(r_j + 1'b1) == r_cnt;
        last_k   = CNT_W'(r_k + 1'b1) == r_cnt;
        pair_hit = (r_j != r_i) && !is_empty(box_rd) && near_box(r_bi, box_rd) &&
                   (lab_rd != r_li);
        root_i   = lab_rd == r_i[IDX_W-1:0];
    end

    // read addresses
    always_comb begin
        box_ra = (r_state == ST_PJ_RD) ? r_j[IDX_W-1:0] : r_i[IDX_W-1:0];
        if (r_state == ST_PJ_RD) begin
            lab_ra = r_j[IDX_W-1:0];
        end else if (r_state == ST_SW_RD) begin
            lab_ra = r_k[IDX_W-1:0];
        end else begin
            lab_ra = r_i[IDX_W-1:0];
        end
        acc_ra = (r_state == ST_ACC_GET) ? cof_rd.c : r_i[IDX_W-1:0];
        av_ra  = (r_state == ST_NST_RDJ) ? r_j[IDX_W-1:0] : r_i[IDX_W-1:0];
    end

    // write controls
    always_comb begin
        box_we = load_acc && (r_cnt < MAX_C);
        box_wd = '{x: i_box_left, y: i_box_top, w: i_box_width, h: i_box_height,
                   s: i_box_score};

        lab_we = box_we;
        lab_wa = r_cnt[IDX_W-1:0];
        lab_wd = r_cnt[IDX_W-1:0];
        if (r_state == ST_SW_CHK) begin
            lab_we = lab_rd == r_hi;
            lab_wa = r_k[IDX_W-1:0];
            lab_wd = r_lo;
        end

        num_we = (r_state == ST_NUM_GET) && !is_empty(box_rd) && root_i;

        cof_we = ((r_state == ST_NUM_GET) && (is_empty(box_rd) || root_i)) ||
                 (r_state == ST_NUM_MAP);
        if (r_state == ST_NUM_MAP) begin
            cof_wd = '{v: 1'b1, c: num_rd};
        end else begin
            cof_wd = '{v: !is_empty(box_rd), c: r_cc[IDX_W-1:0]};
        end

        acc_we = 1'b0;
        acc_wa = r_i[IDX_W-1:0];
        acc_wd = '0;
        if (r_state == ST_CLR) begin
            acc_we = r_i != r_cc;
        end else if (r_state == ST_ACC_UPD) begin
            acc_we    = 1'b1;
            acc_wa    = r_c;
            acc_wd.sx = acc_rd.sx + SUM_W'(r_bj.x);
            acc_wd.sy = acc_rd.sy + SUM_W'(r_bj.y);
            acc_wd.sw = acc_rd.sw + SUM_W'(r_bj.w);
            acc_wd.sh = acc_rd.sh + SUM_W'(r_bj.h);
            acc_wd.n  = acc_rd.n + 1'b1;
            acc_wd.best = ((acc_rd.n == '0) ||
                           ($signed(r_bj.s) > $signed(acc_rd.best))) ? r_bj.s : acc_rd.best;
        end

        av_we = (r_state == ST_AVG_WAIT) && div_done && (r_q == 2'd3);
        av_wd = '{x: r_avx, y: r_avy, w: r_avw, h: div_quot[CB-1:0], n: r_acc.n,
                  s: r_acc.best};
    end

    // registered-read memories
    always_ff @(posedge i_clk) begin
        if (box_we) begin
            m_box[r_cnt[IDX_W-1:0]] <= box_wd;
        end
        box_rd <= m_box[box_ra];
    end

    always_ff @(posedge i_clk) begin
        if (lab_we) begin
            m_lab[lab_wa] <= lab_wd;
        end
        lab_rd <= m_lab[lab_ra];
    end

    always_ff @(posedge i_clk) begin
        if (num_we) begin
            m_num[r_i[IDX_W-1:0]] <= r_cc[IDX_W-1:0];
        end
        num_rd <= m_num[lab_rd];
    end

    always_ff @(posedge i_clk) begin
        if (cof_we) begin
            m_cof[r_i[IDX_W-1:0]] <= cof_wd;
        end
        cof_rd <= m_cof[r_i[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            m_acc[acc_wa] <= acc_wd;
        end
        acc_rd <= m_acc[acc_ra];
    end

    always_ff @(posedge i_clk) begin
        if (av_we) begin
            m_av[r_kept[IDX_W-1:0]] <= av_wd;
        end
        av_rd <= m_av[av_ra];
    end

    // divider operands: rounded mean (2s+n)/(2n)
    always_comb begin
        case (r_q)
            2'd0:    sel_sum = r_acc.sx;
            2'd1:    sel_sum = r_acc.sy;
            2'd2:    sel_sum = r_acc.sw;
            default: sel_sum = r_acc.sh;
        endcase
        dividend  = {sel_sum, 1'b0} + DVD_W'(r_acc.n);
        divisor   = {r_acc.n, 1'b0};
        div_start = r_state == ST_AVG_DIV;
    end

    gbx_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // result strobe: a released survivor or the closing result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= (r_state == ST_DONE) ||
                         ((r_state == ST_NST_RDJ) && (r_j == r_kept) && r_pend);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_min     <= CNT_W'(1);
            r_cnt     <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_cc      <= '0;
            r_kept    <= '0;
            r_q       <= '0;
            r_pend    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min <= i_cfg_wdata;
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (start) begin
                        if (r_cnt < MAX_C) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (i_final_box) begin
                            r_i     <= '0;
                            r_state <= ST_PI_RD;
                        end
                    end
                end
                ST_PI_RD: r_state <= ST_PI_GET;
                ST_PI_GET: begin
                    r_bi <= box_rd;
                    r_li <= lab_rd;
                    if (!is_empty(box_rd)) begin
                        r_j     <= '0;
                        r_state <= ST_PJ_RD;
                    end else if (last_i) begin
                        r_i     <= '0;
                        r_cc    <= '0;
                        r_state <= ST_NUM_RD;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_PI_RD;
                    end
                end
                ST_PJ_RD: r_state <= ST_PJ_CHK;
                ST_PJ_CHK: begin
                    if (pair_hit) begin
                        r_lo    <= (lab_rd < r_li) ? lab_rd : r_li;
                        r_hi    <= (lab_rd < r_li) ? r_li : lab_rd;
                        r_li    <= (lab_rd < r_li) ? lab_rd : r_li;
                        r_k     <= '0;
                        r_state <= ST_SW_RD;
                    end else if (!last_j) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= ST_PJ_RD;
                    end else if (!last_i) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_PI_RD;
                    end else begin
                        r_i     <= '0;
                        r_cc    <= '0;
                        r_state <= ST_NUM_RD;
                    end
                end
                ST_SW_RD: r_state <= ST_SW_CHK;
                ST_SW_CHK: begin
                    // relabel sweep merges the higher label into the lower
                    if (!last_k) begin
                        r_k     <= r_k + 1'b1;
                        r_state <= ST_SW_RD;
                    end else if (!last_j) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= ST_PJ_RD;
                    end else if (!last_i) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_PI_RD;
                    end else begin
                        r_i     <= '0;
                        r_cc    <= '0;
                        r_state <= ST_NUM_RD;
                    end
                end
                ST_NUM_RD: r_state <= ST_NUM_GET;
                ST_NUM_GET: begin
                    if (!is_empty(box_rd) && !root_i) begin
                        r_state <= ST_NUM_MAP;
                    end else begin
                        if (!is_empty(box_rd)) begin
                            r_cc <= r_cc + 1'b1;
                        end
                        r_i     <= last_i ? '0 : r_i + 1'b1;
                        r_state <= last_i ? ST_CLR : ST_NUM_RD;
                    end
                end
                ST_NUM_MAP: begin
                    r_i     <= last_i ? '0 : r_i + 1'b1;
                    r_state <= last_i ? ST_CLR : ST_NUM_RD;
                end
                ST_CLR: begin
                    if (r_i == r_cc) begin
                        r_i     <= '0;
                        r_state <= ST_ACC_RD;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                ST_ACC_RD: r_state <= ST_ACC_GET;
                ST_ACC_GET: begin
                    r_bj <= box_rd;
                    r_c  <= cof_rd.c;
                    if (cof_rd.v) begin
                        r_state <= ST_ACC_UPD;
                    end else begin
                        r_i     <= last_i ? '0 : r_i + 1'b1;
                        r_kept  <= '0;
                        r_state <= last_i ? ST_AVG_RD : ST_ACC_RD;
                    end
                end
                ST_ACC_UPD: begin
                    r_i     <= last_i ? '0 : r_i + 1'b1;
                    r_kept  <= '0;
                    r_state <= last_i ? ST_AVG_RD : ST_ACC_RD;
                end
                ST_AVG_RD: begin
                    if (r_i == r_cc) begin
                        r_i     <= '0;
                        r_state <= ST_NST_RDI;
                    end else begin
                        r_state <= ST_AVG_GET;
                    end
                end
                ST_AVG_GET: begin
                    r_acc <= acc_rd;
                    if ((acc_rd.n == '0) || (acc_rd.n < r_min)) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_AVG_RD;
                    end else begin
                        r_q     <= '0;
                        r_state <= ST_AVG_DIV;
                    end
                end
                ST_AVG_DIV: r_state <= ST_AVG_WAIT;
                ST_AVG_WAIT: begin
                    if (div_done) begin
                        case (r_q)
                            2'd0:    r_avx <= div_quot[CB-1:0];
                            2'd1:    r_avy <= div_quot[CB-1:0];
                            default: r_avw <= div_quot[CB-1:0];
                        endcase
                        if (r_q == 2'd3) begin
                            r_kept  <= r_kept + 1'b1;
                            r_i     <= r_i + 1'b1;
                            r_state <= ST_AVG_RD;
                        end else begin
                            r_q     <= r_q + 1'b1;
                            r_state <= ST_AVG_DIV;
                        end
                    end
                end
                ST_NST_RDI: begin
                    r_state <= (r_i == r_kept) ? ST_DONE : ST_NST_GETI;
                end
                ST_NST_GETI: begin
                    r_ai    <= av_rd;
                    r_j     <= '0;
                    r_state <= ST_NST_RDJ;
                end
                ST_NST_RDJ: begin
                    if (r_j == r_kept) begin
                        // survivor: release the one held back, hold this one
                        if (r_pend) begin
                            r_o_has   <= 1'b1;
                            r_o_final <= 1'b0;
                            r_o_box   <= r_pbox;
                        end
                        r_pbox  <= r_ai;
                        r_pend  <= 1'b1;
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_NST_RDI;
                    end else begin
                        r_state <= ST_NST_CHK;
                    end
                end
                ST_NST_CHK: begin
                    if ((r_j != r_i) && nested_in(r_ai, av_rd)) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= ST_NST_RDI;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= ST_NST_RDJ;
                    end
                end
                ST_DONE: begin
                    r_o_final <= 1'b1;
                    r_o_has   <= r_pend;
                    r_o_box   <= r_pend ? r_pbox : '0;
                    r_pend    <= 1'b0;
                    r_cnt     <= '0;
                    r_state   <= ST_LOAD;
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    // outputs
    assign busy           = r_state != ST_LOAD;
    assign o_valid        = r_o_valid;
    assign o_has_box      = r_o_has;
    assign o_out_left     = r_o_box.x;
    assign o_out_top      = r_o_box.y;
    assign o_out_width    = r_o_box.w;
    assign o_out_height   = r_o_box.h;
    assign o_member_total = r_o_box.n;
    assign o_out_score    = r_o_box.s;
    assign o_final_result = r_o_final;

endmodule

FILE: rtl/gbx_div.sv
// ----------------------------------------------------------------------------
// gbx_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gbx_div #(
    parameter int DVD_W = 20,
    parameter int DVS_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_steps;
    logic              r_done;
    logic [DVS_W:0]    rem_sh;
    logic              ge;
    logic [DVS_W:0]    diff;

    // trial subtract of the shifted remainder
    always_comb begin
        rem_sh = {r_rem, r_quo[DVD_W-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
        diff   = rem_sh - {1'b0, r_dvs};
    end

    // iteration control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= !i_start && (r_steps == STEP_W'(1));
            if (i_start) begin
                r_quo   <= i_dividend;
                r_rem   <= '0;
                r_dvs   <= i_divisor;
                r_steps <= STEP_W'(DVD_W);
            end else if (r_steps != '0) begin
                r_rem   <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
                r_quo   <= {r_quo[DVD_W-2:0], ge};
                r_steps <= r_steps - 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

FILE: rtl/gbx_chk.sv
// ----------------------------------------------------------------------------
// gbx_chk
// port-level checks of the box grouping block
// ----------------------------------------------------------------------------
`include "detection_box_grouping_top_defines.svh"

module gbx_chk
    import gbx_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic [COORD_BITS-1:0]          i_box_left,
    input logic [COORD_BITS-1:0]          i_box_top,
    input logic [COORD_BITS-1:0]          i_box_width,
    input logic [COORD_BITS-1:0]          i_box_height,
    input logic signed [SCORE_W-1:0]      i_box_score,
    input logic                           i_final_box,
    input logic                           i_cfg_we,
    input logic [$clog2(MAX_BOXES+1)-1:0] i_cfg_wdata,
    input logic                           o_valid,
    input logic                           o_has_box,
    input logic [COORD_BITS-1:0]          o_out_left,
    input logic [COORD_BITS-1:0]          o_out_top,
    input logic [COORD_BITS-1:0]          o_out_width,
    input logic [COORD_BITS-1:0]          o_out_height,
    input logic [$clog2(MAX_BOXES+1)-1:0] o_member_total,
    input logic signed [SCORE_W-1:0]      o_out_score,
    input logic                           o_final_result
);

    // a result without a box is always the closing result
    `GBX_ASSERT_NOW(a_empty_final, o_valid && !o_has_box, o_final_result)

    // an empty result carries zero left, width, member total and score
    `GBX_ASSERT_NOW(a_empty_zero, o_valid && !o_has_box,
        o_out_left == '0 && o_out_width == '0 && o_member_total == '0 && o_out_score == '0)

    // a grouped box always has members
    `GBX_ASSERT_NOW(a_members, o_valid && o_has_box, o_member_total != '0)

    // nothing follows the closing result
    `GBX_ASSERT_NXT(a_after_final, o_valid && o_final_result, !o_valid)

    // a non-final request produces no result
    `GBX_ASSERT_NXT(a_load_quiet, start && !busy && !i_final_box, !o_valid && !busy)

endmodule

bind detection_box_grouping_top gbx_chk #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_BITS (COORD_BITS)
) u_gbx_chk (.*);
